// ===== src/srz_pkg.sv =====
// Shared constants, register codes and pipeline types for the sprite rotate and zoom block.
package srz_pkg;

    localparam int MAX_DIM   = 64;
    localparam int FRAC_BITS = 16;

    localparam int POS_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int ZOOM_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ZOOM_W;

    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int ADDR_W   = 2 * DIM_BITS;
    localparam int HALF_W   = SIZE_W - 1;
    localparam int XT_W     = ((POS_W > HALF_W) ? POS_W : HALF_W) + 1;
    localparam int PROD_W   = ZOOM_W + XT_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FLR_W    = SUM_W - FRAC_BITS;
    localparam int SRC_W    = ((FLR_W > SIZE_W) ? FLR_W : SIZE_W) + 1;

    localparam int WIDTH_RESET  = 64;
    localparam int HEIGHT_RESET = 64;
    localparam int COS_RESET    = 65536;
    localparam int SIN_RESET    = 0;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COS    = 2'd2,
        CFG_SIN    = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             pixel_in;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } tag_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
        logic [HALF_W-1:0]        half_w;
        logic [HALF_W-1:0]        half_h;
        logic signed [ZOOM_W-1:0] cos_zoom;
        logic signed [ZOOM_W-1:0] sin_zoom;
    } geom_cfg_t;

    typedef struct packed {
        logic              valid;
        logic              rd;
        logic              wr_en;
        logic              pixel_in;
        logic              in_bounds;
        logic [ADDR_W-1:0] addr;
    } mem_op_t;

endpackage

// ===== src/srz_map.sv =====
// Coordinate mapping pipeline: centering, rotation products, floor and bounds check.
module srz_map
    import srz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  tag_t      tag_in,
    input  geom_cfg_t geom,
    output mem_op_t   op
);

    logic  valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    item_t item_a_reg, item_b_reg, item_c_reg;

    logic signed [XT_W-1:0]   xt, yt;
    logic signed [PROD_W-1:0] p_cx_next, p_sy_next, p_sx_next, p_cy_next;
    logic signed [PROD_W-1:0] p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [FLR_W-1:0]  flr_x_next, flr_y_next, flr_x_reg, flr_y_reg;
    logic signed [SRC_W-1:0]  xs, ys;
    mem_op_t                  op_next, op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= tag_in.valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    // Center the destination position on the sprite.
    assign xt = $signed(XT_W'(item_a_reg.pos_x)) - $signed(XT_W'(geom.half_w));
    assign yt = $signed(XT_W'(item_a_reg.pos_y)) - $signed(XT_W'(geom.half_h));

    assign p_cx_next = geom.cos_zoom * xt;
    assign p_sy_next = geom.sin_zoom * yt;
    assign p_sx_next = geom.sin_zoom * xt;
    assign p_cy_next = geom.cos_zoom * yt;

    // Dropping the fraction bits of a two's complement value floors toward minus infinity.
    assign sum_x      = SUM_W'(p_cx_reg) - SUM_W'(p_sy_reg);
    assign sum_y      = SUM_W'(p_sx_reg) + SUM_W'(p_cy_reg);
    assign flr_x_next = sum_x[SUM_W-1:FRAC_BITS];
    assign flr_y_next = sum_y[SUM_W-1:FRAC_BITS];

    assign xs = SRC_W'(flr_x_reg) + $signed(SRC_W'(geom.half_w));
    assign ys = SRC_W'(flr_y_reg) + $signed(SRC_W'(geom.half_h));

    always_comb
    begin
        op_next           = '0;
        op_next.valid     = valid_c_reg;
        op_next.rd        = (item_c_reg.kind == KIND_READ);
        op_next.wr_en     = (item_c_reg.kind == KIND_WRITE)
                            && (int'(item_c_reg.pos_x) < MAX_DIM)
                            && (int'(item_c_reg.pos_y) < MAX_DIM);
        op_next.pixel_in  = item_c_reg.pixel_in;
        op_next.in_bounds = !xs[SRC_W-1] && (xs < $signed(SRC_W'(geom.width)))
                            && !ys[SRC_W-1] && (ys < $signed(SRC_W'(geom.height)));
        if (op_next.rd)
        begin
            op_next.addr = {ys[DIM_BITS-1:0], xs[DIM_BITS-1:0]};
        end
        else
        begin
            op_next.addr = {DIM_BITS'(item_c_reg.pos_y), DIM_BITS'(item_c_reg.pos_x)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_a_reg <= tag_in.item;
            item_b_reg <= item_a_reg;
            item_c_reg <= item_b_reg;
            p_cx_reg   <= p_cx_next;
            p_sy_reg   <= p_sy_next;
            p_sx_reg   <= p_sx_next;
            p_cy_reg   <= p_cy_next;
            flr_x_reg  <= flr_x_next;
            flr_y_reg  <= flr_y_next;
            op_reg     <= op_next;
        end
    end

    always_comb
    begin
        op       = op_reg;
        op.valid = valid_d_reg;
    end

endmodule

// ===== src/srz_store.sv =====
// One-bit source image memory with one write port and one registered read port.
module srz_store
    import srz_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  mem_op_t op,
    output logic    rd_bit
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic mem [DEPTH];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (en && op.valid && op.wr_en)
        begin
            mem[op.addr] <= op.pixel_in;
        end
        if (en)
        begin
            rd_bit_reg <= mem[op.addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

// ===== src/sprite_rotate_zoom_core.sv =====
// A read item's result is shown once it has passed the input, product, floor, address and output registers.
// One item per cycle while no shown result is stalled; the five register stages advance together.
// The whole pipeline holds while a shown result is stalled, so in_stall follows out_stall.
// Reset clears all valid bits and loads width 64, height 64, cos_zoom 1.0 and sin_zoom 0.
// The image memory is not cleared; a read of a never-written entry returns any value.
module sprite_rotate_zoom_core
    import srz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic                  pixel_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pixel_out,
    output logic                  inside_res,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sizes are kept already clamped to the range 1 to MAX_DIM, so the
    // datapath never sees a zero or oversized sprite.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = SIZE_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [SIZE_W-1:0]        width_reg, height_reg;
    logic signed [ZOOM_W-1:0] cos_reg, sin_reg;
    geom_cfg_t                geom;

    logic    adv;
    tag_t    tag_in;
    mem_op_t op;
    logic    rd_bit;
    logic    out_valid_reg;
    logic    inside_reg;

    // Configuration is taken in every cycle; software must write it only while no
    // item is in flight, and the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(WIDTH_RESET);
            height_reg <= SIZE_W'(HEIGHT_RESET);
            cos_reg    <= ZOOM_W'(COS_RESET);
            sin_reg    <= ZOOM_W'(SIN_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= clamp_size(cfg_data[SIZE_W-1:0]);
                CFG_HEIGHT: height_reg <= clamp_size(cfg_data[SIZE_W-1:0]);
                CFG_COS:    cos_reg    <= cfg_data[ZOOM_W-1:0];
                CFG_SIN:    sin_reg    <= cfg_data[ZOOM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        geom.width    = width_reg;
        geom.height   = height_reg;
        geom.half_w   = width_reg[SIZE_W-1:1];
        geom.half_h   = height_reg[SIZE_W-1:1];
        geom.cos_zoom = cos_reg;
        geom.sin_zoom = sin_reg;
    end

    // All stages move together. They hold only when the output register
    // carries a result that the receiver is stalling; otherwise bubbles and
    // write items simply flow through.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        tag_in.valid         = in_valid;
        tag_in.item.kind     = kind;
        tag_in.item.pos_x    = pos_x;
        tag_in.item.pos_y    = pos_y;
        tag_in.item.pixel_in = pixel_in;
    end

    // Stages one to four: input register, rotation products, floored sums,
    // and source position with bounds check and memory address.
    srz_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .tag_in (tag_in),
        .geom   (geom),
        .op     (op)
    );

    // Writes and reads reach the memory in the same stage and in item order,
    // so a read always sees every write that was accepted before it.
    srz_store u_store (
        .clk    (clk),
        .en     (adv),
        .op     (op),
        .rd_bit (rd_bit)
    );

    // Stage five: the output register, aligned with the registered read data.
    // Write items leave no result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= op.valid && op.rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inside_reg <= op.in_bounds;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign pixel_out  = rd_bit & inside_reg;

endmodule

// ===== src/srz_checker.sv =====
// Port-level checks for the sprite rotate and zoom block, bound to its top level.
module srz_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pixel_out,
    input logic inside_res,
    input logic cfg_ready
);

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled input item stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input item withdrawn while stalled");

    // The pipeline only backs up when a shown result is being stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A position outside the sprite always reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> !pixel_out)
        else $error("pixel set outside the sprite");

    // Register writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind sprite_rotate_zoom_core srz_checker u_srz_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .inside_res (inside_res),
    .cfg_ready  (cfg_ready)
);
